[rtl/core/crypto1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crypto1 package
// Shared types, command codes and the nonlinear filter function.
// ----------------------------------------------------------------------------
package crypto1_pkg;

	localparam int HALF_W = 24;
	localparam int KEY_W  = 48;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int APB_DW = 64;
	localparam int APB_AW = 4;
	localparam int STEP_W = $clog2(DATA_W);

	localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WORD  = 3'd4;

	localparam logic [HALF_W-1:0] POLY_ODD  = 24'h29CE5C;
	localparam logic [HALF_W-1:0] POLY_EVEN = 24'h870804;

	localparam logic [19:0] FILT_A = 20'hf22c0;
	localparam logic [19:0] FILT_B = 20'h6c9c0;
	localparam logic [19:0] FILT_C = 20'h3c8b0;
	localparam logic [19:0] FILT_D = 20'h1e458;
	localparam logic [19:0] FILT_E = 20'h0d938;
	localparam logic [31:0] FILT_F = 32'hEC57E80A;

	// word order of steps: big-endian bytes within the 32-bit word
	localparam logic [STEP_W-1:0] WORD_SWAP = 5'd24;

	localparam logic [STEP_W-1:0] LAST_BIT  = 5'd0;
	localparam logic [STEP_W-1:0] LAST_BYTE = 5'd7;
	localparam logic [STEP_W-1:0] LAST_WORD = 5'd31;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
		logic bit_in;
		logic enc;
	} ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// two-level filter: five 4-input lookups pick a 5-bit index into the last table
	function automatic logic filt(input logic [HALF_W-1:0] x);
		logic [4:0] idx;
		idx[4] = FILT_A[5'(x[3:0]) + 5'd4];
		idx[3] = FILT_B[5'(x[7:4]) + 5'd3];
		idx[2] = FILT_C[5'(x[11:8]) + 5'd2];
		idx[1] = FILT_D[5'(x[15:12]) + 5'd1];
		idx[0] = FILT_E[5'(x[19:16])];
		return FILT_F[idx];
	endfunction

endpackage

[rtl/core/crypto1_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crypto1 stream channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface crypto1_req_if
	import crypto1_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [DATA_W-1:0] data_in;
	logic              encrypted;

	modport source (output valid, output command, output data_in, output encrypted,
		input ready);
	modport sink (input valid, input command, input data_in, input encrypted,
		output ready);
endinterface

interface crypto1_rsp_if
	import crypto1_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic              filter_out;

	modport source (output valid, output data_out, output filter_out, input ready);
	modport sink (input valid, input data_out, input filter_out, output ready);
endinterface

[rtl/core/crypto1_apb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crypto1 register port
// APB-style access to the 48-bit key register.
// ----------------------------------------------------------------------------
module crypto1_apb
	import crypto1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [KEY_W-1:0]  key
);

	logic [KEY_W-1:0] key_q;
	logic             key_sel;

	// register index sits in address bit 3
	assign key_sel = (paddr[3] == 1'b0);
	assign pready  = 1'b1;
	assign key     = key_q;
	assign prdata  = key_sel ? {{(APB_DW-KEY_W){1'b0}}, key_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && key_sel) begin
			key_q <= pwdata[KEY_W-1:0];
		end
	end

endmodule

[rtl/core/crypto1_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crypto1 LFSR unit
// Odd/even state halves and filter; one feedback step per cycle on ctrl.step.
// ----------------------------------------------------------------------------
module crypto1_core
	import crypto1_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	input  logic [KEY_W-1:0] key,
	output logic             ks,
	output logic             filt_next
);

	logic [HALF_W-1:0] odd_q, even_q;
	logic [HALF_W-1:0] odd_d, even_d;
	logic [HALF_W-1:0] key_odd, key_even;
	logic              fb;

	// key bit (2j)^7 to odd[j], (2j+1)^7 to even[j]
	always_comb begin
		for (int j = 0; j < HALF_W; j++) begin
			key_odd[j]  = key[(2*j) ^ 7];
			key_even[j] = key[(2*j+1) ^ 7];
		end
	end

	assign ks = filt(odd_q);
	assign fb = (ks & ctrl.enc) ^ ctrl.bit_in ^ (^((POLY_ODD & odd_q) ^ (POLY_EVEN & even_q)));

	always_comb begin
		odd_d  = odd_q;
		even_d = even_q;
		if (ctrl.load) begin
			odd_d  = key_odd;
			even_d = key_even;
		end else if (ctrl.clear) begin
			odd_d  = '0;
			even_d = '0;
		end else if (ctrl.step) begin
			// shift feedback into even, then swap halves
			odd_d  = {even_q[HALF_W-2:0], fb};
			even_d = odd_q;
		end
	end

	assign filt_next = filt(odd_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q  <= '0;
			even_q <= '0;
		end else begin
			odd_q  <= odd_d;
			even_q <= even_d;
		end
	end

endmodule

[rtl/core/crypto1_stream_cipher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crypto1 stream cipher
// Command-driven 48-bit Crypto1 LFSR with keystream output.
// ----------------------------------------------------------------------------
// Each command word is taken in a valid/ready handshake. Init, clear and the
// unused codes finish in the cycle they are taken. Bit, byte and word clocking
// then step the single LFSR unit once per cycle for 1, 8 or 32 steps, and the
// next command is taken only after the last step. The result word sits in an
// output register. A new command is taken only when that register is empty,
// or in the cycle its word leaves, so a stalled result stalls the input. The
// key register at byte address 0 is 48 bits wide on a 64-bit port and should
// be written while the cipher is idle.
// ----------------------------------------------------------------------------
module crypto1_stream_cipher_top
	import crypto1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	crypto1_req_if.sink       req,
	crypto1_rsp_if.source     rsp
);

	state_t            st_q;
	logic [STEP_W-1:0] step_q, last_q, pos;
	logic              word_q, enc_q;
	logic [DATA_W-1:0] din_q, work_q, work_d;
	logic [DATA_W-1:0] out_data_q;
	logic              out_flt_q, ovalid_q;
	logic              acc, finish, is_clock;
	logic [KEY_W-1:0]  key;
	logic              ks, filt_next;
	ctrl_t             ctrl;

	crypto1_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	crypto1_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.key       (key),
		.ks        (ks),
		.filt_next (filt_next)
	);

	assign req.ready = (st_q == ST_IDLE) && (!ovalid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign pos       = word_q ? (step_q ^ WORD_SWAP) : step_q;
	assign finish    = (st_q == ST_RUN) && (step_q == last_q);
	assign is_clock  = req.command inside {CMD_BIT, CMD_BYTE, CMD_WORD};

	always_comb begin
		work_d      = work_q;
		work_d[pos] = ks;
	end

	always_comb begin
		ctrl        = '0;
		ctrl.enc    = enc_q;
		ctrl.bit_in = din_q[pos];
		ctrl.step   = (st_q == ST_RUN);
		if (acc) begin
			ctrl.load  = (req.command == CMD_INIT);
			ctrl.clear = (req.command == CMD_CLEAR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc && is_clock) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (finish || (acc && !is_clock)) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			step_q <= '0;
			din_q  <= req.data_in;
			enc_q  <= req.encrypted;
			word_q <= (req.command == CMD_WORD);
			work_q <= '0;
			case (req.command)
				CMD_BIT:  last_q <= LAST_BIT;
				CMD_BYTE: last_q <= LAST_BYTE;
				CMD_WORD: last_q <= LAST_WORD;
				default: begin
					last_q     <= LAST_BIT;
					out_data_q <= '0;
					out_flt_q  <= filt_next;
				end
			endcase
		end else if (st_q == ST_RUN) begin
			work_q <= work_d;
			step_q <= step_q + 1'b1;
			if (finish) begin
				out_data_q <= work_d;
				out_flt_q  <= filt_next;
			end
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.data_out   = out_data_q;
	assign rsp.filter_out = out_flt_q;

endmodule
